@@ rtl/b58enc_pkg.sv @@
// Shared types, constants and the character table of the base58 encoder.
// No dependencies; imported by every module of the block.
`default_nettype none
package b58enc_pkg;

	localparam int unsigned STORE_DEPTH = 45;
	localparam int unsigned IDX_W       = 6;
	localparam int unsigned DIGIT_W     = 6;
	localparam int unsigned CARRY_W     = 9;
	localparam int unsigned CAP_W       = 7;
	localparam int unsigned MAX_INPUT   = 32;
	localparam int unsigned RADIX       = 58;
	// floor(2^16 / 58): quotient estimate is exact or one short
	localparam int unsigned RECIP       = 1129;
	localparam int unsigned RECIP_SHIFT = 16;
	localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

	typedef logic [IDX_W-1:0]   idx_t;
	typedef logic [DIGIT_W-1:0] digit_t;
	typedef logic [CARRY_W-1:0] carry_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_IN_OVF  = 2'd1,
		ST_OUT_OVF = 2'd2
	} status_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last;
	} item_t;

	typedef struct packed {
		logic [7:0] out_char;
		status_t    status;
		logic       final_res;
	} result_t;

	typedef struct packed {
		logic   rd_en;
		idx_t   rd_addr;
		logic   wr_en;
		idx_t   wr_addr;
		digit_t wr_data;
		logic   clr;
	} store_req_t;

	function automatic logic [7:0] b58_char(input digit_t d);
		logic [7:0] c;
		case (d)
			6'd0:  c = "1";  6'd1:  c = "2";  6'd2:  c = "3";  6'd3:  c = "4";
			6'd4:  c = "5";  6'd5:  c = "6";  6'd6:  c = "7";  6'd7:  c = "8";
			6'd8:  c = "9";  6'd9:  c = "A";  6'd10: c = "B";  6'd11: c = "C";
			6'd12: c = "D";  6'd13: c = "E";  6'd14: c = "F";  6'd15: c = "G";
			6'd16: c = "H";  6'd17: c = "J";  6'd18: c = "K";  6'd19: c = "L";
			6'd20: c = "M";  6'd21: c = "N";  6'd22: c = "P";  6'd23: c = "Q";
			6'd24: c = "R";  6'd25: c = "S";  6'd26: c = "T";  6'd27: c = "U";
			6'd28: c = "V";  6'd29: c = "W";  6'd30: c = "X";  6'd31: c = "Y";
			6'd32: c = "Z";  6'd33: c = "a";  6'd34: c = "b";  6'd35: c = "c";
			6'd36: c = "d";  6'd37: c = "e";  6'd38: c = "f";  6'd39: c = "g";
			6'd40: c = "h";  6'd41: c = "i";  6'd42: c = "j";  6'd43: c = "k";
			6'd44: c = "m";  6'd45: c = "n";  6'd46: c = "o";  6'd47: c = "p";
			6'd48: c = "q";  6'd49: c = "r";  6'd50: c = "s";  6'd51: c = "t";
			6'd52: c = "u";  6'd53: c = "v";  6'd54: c = "w";  6'd55: c = "x";
			6'd56: c = "y";  6'd57: c = "z";
			default: c = 8'd0;
		endcase
		return c;
	endfunction

endpackage
`default_nettype wire

@@ rtl/base58_encoder_unit.sv @@
// Base58 (Bitcoin alphabet) encoder, top level: control sequencer, config register.
// Depends on b58enc_pkg, b58enc_store and b58enc_step.
//
//  channel   signals                         transaction when
//  item      start, busy, item               start && !busy
//  result    result_strobe, result           result_strobe (one cycle, no stall)
//  config    cfg_valid, cfg_ready, cfg_data  cfg_valid && cfg_ready
//
// A leading zero byte or a byte past the input limit is only counted or flagged at
// accept. For any other byte the store read-modify-write then walks all 45 digits,
// one per cycle through the store's read and write ports, with a registered read.
// A last byte then adds a length check and emits one character per cycle.
// After reset the store reads as zero at once. The receiver cannot stall.
`default_nettype none
module base58_encoder_unit
	import b58enc_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	output logic                  busy,
	input  wire item_t            item,
	output logic                  result_strobe,
	output result_t               result,
	input  wire logic             cfg_valid,
	output logic                  cfg_ready,
	input  wire logic [CAP_W-1:0] cfg_data
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL,
		S_FIN,
		S_ZEROS,
		S_DIGITS
	} state_t;

	state_t           state_q;
	logic [CAP_W-1:0] cap_q;
	idx_t             bc_q;
	idx_t             zpc_q;
	logic             izp_q;
	logic             ovf_q;
	logic             last_q;
	carry_t           carry_q;
	idx_t             rd_idx_q;
	logic             iss_done_q;
	logic             rd_pend_s1;
	idx_t             wr_idx_s1;
	idx_t             first_q;
	idx_t             zleft_q;
	logic             res_strobe_q;
	result_t          res_q;

	store_req_t       req;
	digit_t           rd_data;
	digit_t           new_digit;
	carry_t           new_carry;
	logic             accept;
	logic             issue;
	logic [CAP_W-1:0] total;
	logic             too_long;
	logic             msg_done;

	b58enc_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.rd_data (rd_data)
	);

	b58enc_step u_step (
		.digit_in  (rd_data),
		.carry_in  (carry_q),
		.digit_out (new_digit),
		.carry_out (new_carry)
	);

	assign busy          = (state_q != S_IDLE);
	assign accept        = start && !busy;
	assign cfg_ready     = 1'b1;
	assign result_strobe = res_strobe_q;
	assign result        = res_q;
	assign issue         = (state_q == S_MUL) && !iss_done_q;

	always_comb begin
		total    = {1'b0, zpc_q} + (CAP_W'(STORE_DEPTH) - {1'b0, first_q});
		too_long = (total > cap_q) || (total > CAP_W'(STORE_DEPTH));
		msg_done = 1'b0;
		case (state_q)
			S_FIN:    msg_done = ovf_q || too_long || (total == '0);
			S_ZEROS:  msg_done = (zleft_q == IDX_W'(1)) && (first_q == IDX_W'(STORE_DEPTH));
			S_DIGITS: msg_done = (first_q == IDX_W'(STORE_DEPTH - 1));
			default:  msg_done = 1'b0;
		endcase
	end

	always_comb begin
		req         = '0;
		req.clr     = msg_done;
		req.wr_en   = (state_q == S_MUL) && rd_pend_s1;
		req.wr_addr = wr_idx_s1;
		req.wr_data = new_digit;
		case (state_q)
			S_MUL: begin
				req.rd_en   = issue;
				req.rd_addr = rd_idx_q;
			end
			S_FIN, S_ZEROS: begin
				req.rd_en   = 1'b1;
				req.rd_addr = first_q;
			end
			S_DIGITS: begin
				// prefetch the next digit
				req.rd_en   = 1'b1;
				req.rd_addr = first_q + IDX_W'(1);
			end
			default: begin
				req.rd_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			cap_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			bc_q         <= '0;
			zpc_q        <= '0;
			izp_q        <= 1'b1;
			ovf_q        <= 1'b0;
			last_q       <= 1'b0;
			carry_q      <= '0;
			rd_idx_q     <= '0;
			iss_done_q   <= 1'b1;
			rd_pend_s1   <= 1'b0;
			wr_idx_s1    <= '0;
			first_q      <= IDX_W'(STORE_DEPTH);
			zleft_q      <= '0;
			res_strobe_q <= 1'b0;
			res_q        <= '0;
		end else begin
			res_strobe_q <= 1'b0;
			rd_pend_s1   <= issue;
			wr_idx_s1    <= rd_idx_q;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						last_q <= item.last;
						if (ovf_q || (bc_q >= IDX_W'(MAX_INPUT))) begin
							// drop the byte, flag it for the last transaction
							ovf_q   <= 1'b1;
							state_q <= item.last ? S_FIN : S_IDLE;
						end else begin
							bc_q <= bc_q + IDX_W'(1);
							if (izp_q && (item.data_byte == 8'd0)) begin
								zpc_q   <= zpc_q + IDX_W'(1);
								state_q <= item.last ? S_FIN : S_IDLE;
							end else begin
								izp_q      <= 1'b0;
								carry_q    <= CARRY_W'(item.data_byte);
								rd_idx_q   <= IDX_W'(STORE_DEPTH - 1);
								iss_done_q <= 1'b0;
								first_q    <= IDX_W'(STORE_DEPTH);
								state_q    <= S_MUL;
							end
						end
					end
				end
				S_MUL: begin
					if (issue) begin
						if (rd_idx_q == '0) begin
							iss_done_q <= 1'b1;
						end else begin
							rd_idx_q <= rd_idx_q - IDX_W'(1);
						end
					end
					if (rd_pend_s1) begin
						carry_q <= new_carry;
						// walk runs downwards: the last hit is the top digit
						if (new_digit != '0) begin
							first_q <= wr_idx_s1;
						end
						if (wr_idx_s1 == '0) begin
							state_q <= last_q ? S_FIN : S_IDLE;
						end
					end
				end
				S_FIN: begin
					if (ovf_q) begin
						res_strobe_q <= 1'b1;
						res_q        <= '{out_char: 8'd0, status: ST_IN_OVF, final_res: 1'b1};
						state_q      <= S_IDLE;
					end else if (too_long) begin
						res_strobe_q <= 1'b1;
						res_q        <= '{out_char: 8'd0, status: ST_OUT_OVF, final_res: 1'b1};
						state_q      <= S_IDLE;
					end else if (total == '0) begin
						state_q <= S_IDLE;
					end else if (zpc_q != '0) begin
						zleft_q <= zpc_q;
						state_q <= S_ZEROS;
					end else begin
						state_q <= S_DIGITS;
					end
				end
				S_ZEROS: begin
					res_strobe_q <= 1'b1;
					res_q        <= '{out_char: b58_char('0), status: ST_OK,
						final_res: msg_done};
					zleft_q      <= zleft_q - IDX_W'(1);
					if (zleft_q == IDX_W'(1)) begin
						state_q <= msg_done ? S_IDLE : S_DIGITS;
					end
				end
				S_DIGITS: begin
					res_strobe_q <= 1'b1;
					res_q        <= '{out_char: b58_char(rd_data), status: ST_OK,
						final_res: msg_done};
					first_q      <= first_q + IDX_W'(1);
					if (msg_done) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			// clear message state once its last result is decided
			if (msg_done) begin
				bc_q    <= '0;
				zpc_q   <= '0;
				izp_q   <= 1'b1;
				ovf_q   <= 1'b0;
				first_q <= IDX_W'(STORE_DEPTH);
			end
		end
	end

	a_err_single: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && (result.status != ST_OK) |->
			result.final_res && (result.out_char == 8'd0))
		else $error("error result without final marker or with a character");

	a_final_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && result.final_res |-> !busy)
		else $error("block still busy after the final result");

	a_carry_bound: assert property (@(posedge clk) disable iff (!arst_n)
		carry_q <= CARRY_W'(256))
		else $error("carry out of range");

	a_no_collide: assert property (@(posedge clk) disable iff (!arst_n)
		req.wr_en && req.rd_en |-> req.wr_addr != req.rd_addr)
		else $error("store read and write hit the same entry");

endmodule
`default_nettype wire

@@ rtl/b58enc_store.sv @@
// Base-58 digit store: 45 x 6-bit synchronous memory with a registered read.
// Per-entry valid bits make unwritten entries read as zero. Uses b58enc_pkg.
`default_nettype none
module b58enc_store
	import b58enc_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire store_req_t req,
	output digit_t          rd_data
);

	digit_t                 mem [STORE_DEPTH];
	logic [STORE_DEPTH-1:0] vld_q;
	digit_t                 rdata_s1;
	logic                   rvld_s1;
	logic                   rd_ok;
	logic                   wr_ok;

	assign rd_ok = req.rd_en && (req.rd_addr < IDX_W'(STORE_DEPTH));
	assign wr_ok = req.wr_en && (req.wr_addr < IDX_W'(STORE_DEPTH));

	always_ff @(posedge clk) begin
		if (wr_ok) begin
			mem[req.wr_addr] <= req.wr_data;
		end
		if (rd_ok) begin
			rdata_s1 <= mem[req.rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q   <= '0;
			rvld_s1 <= 1'b0;
		end else begin
			if (req.clr) begin
				vld_q <= '0;
			end else if (wr_ok) begin
				vld_q[req.wr_addr] <= 1'b1;
			end
			// out-of-range reads return zero
			if (req.rd_en) begin
				rvld_s1 <= rd_ok && vld_q[req.rd_addr];
			end
		end
	end

	assign rd_data = rvld_s1 ? rdata_s1 : '0;

endmodule
`default_nettype wire

@@ rtl/b58enc_step.sv @@
// One digit of the store * 256 + carry update: digit' = v mod 58, carry' = v / 58.
// Reciprocal multiply with a single correction. Uses b58enc_pkg.
`default_nettype none
module b58enc_step
	import b58enc_pkg::*;
(
	input  wire digit_t digit_in,
	input  wire carry_t carry_in,
	output digit_t      digit_out,
	output carry_t      carry_out
);

	logic [13:0] acc;
	logic [24:0] prod;
	logic [8:0]  q_est;
	logic [13:0] q58;
	logic [13:0] rem_est;

	always_comb begin
		acc     = {digit_in, 8'd0} + 14'(carry_in);
		prod    = 25'(acc) * 25'(RECIP);
		q_est   = prod[RECIP_SHIFT +: 9];
		// 58q = 64q - 4q - 2q
		q58     = {q_est[7:0], 6'd0} - {3'd0, q_est, 2'd0} - {4'd0, q_est, 1'b0};
		rem_est = acc - q58;
		if (rem_est >= 14'(RADIX)) begin
			digit_out = DIGIT_W'(rem_est - 14'(RADIX));
			carry_out = q_est + 9'd1;
		end else begin
			digit_out = DIGIT_W'(rem_est);
			carry_out = q_est;
		end
	end

endmodule
`default_nettype wire
